/* hw/rtl/rpb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rpb_pkg;

  typedef enum logic [2:0] {
    OP_MULTIPLY  = 3'd0,
    OP_SUBTRACT  = 3'd1,
    OP_SCREEN    = 3'd2,
    OP_OVERLAY   = 3'd3,
    OP_ADD       = 3'd4,
    OP_SCALE     = 3'd5,
    OP_REPLICATE = 3'd6,
    OP_PASS      = 3'd7
  } op_t;

  // how the last stage forms a lane's result
  typedef enum logic [1:0] {
    MODE_ALT     = 2'd0,  // precomputed value
    MODE_DIV     = 2'd1,  // round(x/255)
    MODE_DIV_INV = 2'd2,  // 255 - round(x/255)
    MODE_SCALE   = 2'd3   // product clamped to 255
  } mode_t;

  localparam logic [1:0] REG_ADD_AMOUNT     = 2'd0;
  localparam logic [1:0] REG_SCALE_FACTOR   = 2'd1;
  localparam logic [1:0] REG_CHANNEL_SELECT = 2'd2;

  localparam int unsigned LANES   = 3;
  localparam int unsigned NUM_W   = 17;  // 2*255*255 + 127 fits
  // floor(y/255) == (y * RECIP) >> RECIP_SHIFT for y < 2^18
  localparam logic [18:0] RECIP       = 19'd263173;
  localparam int unsigned RECIP_SHIFT = 26;
  localparam logic [16:0] ROUND_BIAS  = 17'd127;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] ma;
    logic [7:0] mb;
    logic       dbl;
    logic [7:0] alt;
  } opnd_t;

  typedef struct packed {
    mode_t             mode;
    logic [NUM_W-1:0]  num;
    logic [7:0]        alt;
  } prod_t;

endpackage

`default_nettype wire

/* hw/rtl/rgb_pixel_blend_unit_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// An accepted item passes through the stage registers s1_r, s2_r and s3_r; out_valid is v3_r.
// Throughput: 1 item per cycle while out_stall is low; the reciprocal multiply for the /255 rounding sets the depth.
// Each stage holds or advances on its own, so bubbles close up under a stall.
// Reset (rst_n low, synchronous) empties the pipeline and sets add_amount 0,
// scale_factor 1, channel_select 2.
module rgb_pixel_blend_unit_top (
  input  wire         clk,
  input  wire         rst_n,
  // input channel
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [2:0]  in_operation,
  input  wire  [7:0]  in_top_blue,
  input  wire  [7:0]  in_top_green,
  input  wire  [7:0]  in_top_red,
  input  wire  [7:0]  in_bottom_blue,
  input  wire  [7:0]  in_bottom_green,
  input  wire  [7:0]  in_bottom_red,
  // result channel
  output logic        out_valid,
  input  wire         out_stall,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  // configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [8:0] add_amount_r;
  logic [7:0] scale_factor_r;
  logic [1:0] channel_select_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_amount_r     <= 9'd0;
      scale_factor_r   <= 8'd1;
      channel_select_r <= 2'd2;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        rpb_pkg::REG_ADD_AMOUNT:     add_amount_r     <= pwdata[8:0];
        rpb_pkg::REG_SCALE_FACTOR:   scale_factor_r   <= pwdata[7:0];
        rpb_pkg::REG_CHANNEL_SELECT: channel_select_r <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      rpb_pkg::REG_ADD_AMOUNT:     prdata = {23'd0, add_amount_r};
      rpb_pkg::REG_SCALE_FACTOR:   prdata = {24'd0, scale_factor_r};
      rpb_pkg::REG_CHANNEL_SELECT: prdata = {30'd0, channel_select_r};
      default:                     prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------
  // Stage handshake: a stage takes new data when it is empty or its
  // contents move on in the same cycle.
  // ---------------------------------------------------------------
  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;

  assign adv3     = !v3_r || !out_stall;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: decode the operation and set up each lane's operands.
  // Lane 0 blue, lane 1 green, lane 2 red.
  // ---------------------------------------------------------------
  logic [7:0] top [rpb_pkg::LANES];
  logic [7:0] bot [rpb_pkg::LANES];

  assign top[0] = in_top_blue;
  assign top[1] = in_top_green;
  assign top[2] = in_top_red;
  assign bot[0] = in_bottom_blue;
  assign bot[1] = in_bottom_green;
  assign bot[2] = in_bottom_red;

  rpb_pkg::op_t  op;
  logic [7:0]    top_sel;
  logic [9:0]    add_sum;
  logic [7:0]    add_clamp;
  logic          cs_ok;

  rpb_pkg::opnd_t s1_nxt [rpb_pkg::LANES];
  rpb_pkg::opnd_t s1_r   [rpb_pkg::LANES];

  assign op    = rpb_pkg::op_t'(in_operation);
  assign cs_ok = (channel_select_r != 2'd3);

  always_comb begin
    unique case (channel_select_r)
      2'd0:    top_sel = in_top_blue;
      2'd1:    top_sel = in_top_green;
      default: top_sel = in_top_red;
    endcase
  end

  // signed 10-bit sum of the channel and the amount, then clamp
  assign add_sum = {2'b00, top_sel} + {add_amount_r[8], add_amount_r};

  always_comb begin
    if (add_sum[9])          add_clamp = 8'd0;
    else if (add_sum[8])     add_clamp = 8'd255;
    else                     add_clamp = add_sum[7:0];
  end

  always_comb begin
    for (int i = 0; i < rpb_pkg::LANES; i++) begin
      s1_nxt[i].mode = rpb_pkg::MODE_ALT;
      s1_nxt[i].ma   = top[i];
      s1_nxt[i].mb   = bot[i];
      s1_nxt[i].dbl  = 1'b0;
      s1_nxt[i].alt  = top[i];
      unique case (op)
        rpb_pkg::OP_MULTIPLY: begin
          s1_nxt[i].mode = rpb_pkg::MODE_DIV;
        end
        rpb_pkg::OP_SUBTRACT: begin
          s1_nxt[i].alt = (top[i] > bot[i]) ? (top[i] - bot[i]) : 8'd0;
        end
        rpb_pkg::OP_SCREEN: begin
          s1_nxt[i].mode = rpb_pkg::MODE_DIV_INV;
          s1_nxt[i].ma   = ~top[i];
          s1_nxt[i].mb   = ~bot[i];
        end
        rpb_pkg::OP_OVERLAY: begin
          s1_nxt[i].dbl = 1'b1;
          if (bot[i][7]) begin
            // bright bottom: screen-like branch on inverted operands
            s1_nxt[i].mode = rpb_pkg::MODE_DIV_INV;
            s1_nxt[i].ma   = ~top[i];
            s1_nxt[i].mb   = ~bot[i];
          end else begin
            s1_nxt[i].mode = rpb_pkg::MODE_DIV;
          end
        end
        rpb_pkg::OP_ADD: begin
          if (cs_ok && channel_select_r == i[1:0]) s1_nxt[i].alt = add_clamp;
        end
        rpb_pkg::OP_SCALE: begin
          if (cs_ok && channel_select_r == i[1:0]) begin
            s1_nxt[i].mode = rpb_pkg::MODE_SCALE;
            s1_nxt[i].mb   = scale_factor_r;
          end
        end
        rpb_pkg::OP_REPLICATE: begin
          if (cs_ok) s1_nxt[i].alt = top_sel;
        end
        rpb_pkg::OP_PASS: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) s1_r <= s1_nxt;
  end

  // ---------------------------------------------------------------
  // Stage 2: 8x8 product, doubled for overlay, plus rounding bias.
  // Scale clamps here since it needs no division.
  // ---------------------------------------------------------------
  rpb_pkg::prod_t s2_nxt [rpb_pkg::LANES];
  rpb_pkg::prod_t s2_r   [rpb_pkg::LANES];
  logic [15:0]    prod   [rpb_pkg::LANES];

  always_comb begin
    for (int i = 0; i < rpb_pkg::LANES; i++) begin
      prod[i]        = s1_r[i].ma * s1_r[i].mb;
      s2_nxt[i].mode = s1_r[i].mode;
      s2_nxt[i].num  = (s1_r[i].dbl ? {prod[i], 1'b0} : {1'b0, prod[i]})
                       + rpb_pkg::ROUND_BIAS;
      if (s1_r[i].mode == rpb_pkg::MODE_SCALE)
        s2_nxt[i].alt = (prod[i][15:8] != 8'd0) ? 8'd255 : prod[i][7:0];
      else
        s2_nxt[i].alt = s1_r[i].alt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) s2_r <= s2_nxt;
  end

  // ---------------------------------------------------------------
  // Stage 3: divide by 255 through the reciprocal, pick the result.
  // ---------------------------------------------------------------
  logic [35:0] recip_prod [rpb_pkg::LANES];
  logic [7:0]  quot       [rpb_pkg::LANES];
  logic [7:0]  s3_nxt     [rpb_pkg::LANES];
  logic [7:0]  s3_r       [rpb_pkg::LANES];

  always_comb begin
    for (int i = 0; i < rpb_pkg::LANES; i++) begin
      recip_prod[i] = {19'd0, s2_r[i].num} * {17'd0, rpb_pkg::RECIP};
      quot[i]       = recip_prod[i][rpb_pkg::RECIP_SHIFT +: 8];
      unique case (s2_r[i].mode)
        rpb_pkg::MODE_DIV:     s3_nxt[i] = quot[i];
        rpb_pkg::MODE_DIV_INV: s3_nxt[i] = ~quot[i];
        default:               s3_nxt[i] = s2_r[i].alt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) s3_r <= s3_nxt;
  end

  assign out_valid = v3_r;
  assign out_blue  = s3_r[0];
  assign out_green = s3_r[1];
  assign out_red   = s3_r[2];

endmodule

`default_nettype wire
